// ===== src/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg - shared types for the LOOK elevator disk scheduler
// Sweep direction codes, field width of the transaction payload and the
// control bundle that travels down the chain of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  // Width of the track and id fields on the ports
  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  // Control bundle handed from cell to cell during a pass
  typedef struct packed {
    logic live;       // a pass is at this point of the chain
    logic pick;       // transaction asks for a grant
    logic add_req;    // add still looking for a free slot
    logic placed;     // add has been stored by an earlier cell
    logic any_above;  // some pending track lies strictly above the head
    logic up_found;   // up candidate carried
    logic dn_found;   // down candidate carried
    logic lo_found;   // lowest-id candidate carried
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/lds_cell.sv =====
// ----------------------------------------------------------------------------
// lds_cell - one pending-request slot of the scheduler chain
// Holds one request, takes an add if free, and folds its entry into the
// nearest-up, nearest-down and lowest-id candidates passing through.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_cell #(
  parameter int TRACK_BITS = 16,
  parameter int IDX_BITS   = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lds_pkg::ctl_t                 ctl_i,
  input  logic [TRACK_BITS-1:0]         head_trk_i,
  input  logic [TRACK_BITS-1:0]         add_trk_i,
  input  logic [lds_pkg::FIELD_BITS-1:0] add_id_i,
  input  logic                          clr_en_i,
  input  logic [IDX_BITS-1:0]           clr_idx_i,
  input  logic [TRACK_BITS-1:0]         up_trk_i,
  input  logic [lds_pkg::FIELD_BITS-1:0] up_id_i,
  input  logic [IDX_BITS-1:0]           up_idx_i,
  input  logic [TRACK_BITS-1:0]         dn_trk_i,
  input  logic [lds_pkg::FIELD_BITS-1:0] dn_id_i,
  input  logic [IDX_BITS-1:0]           dn_idx_i,
  input  logic [TRACK_BITS-1:0]         lo_trk_i,
  input  logic [lds_pkg::FIELD_BITS-1:0] lo_id_i,
  input  logic [IDX_BITS-1:0]           lo_idx_i,
  output lds_pkg::ctl_t                 ctl_o,
  output logic [TRACK_BITS-1:0]         up_trk_o,
  output logic [lds_pkg::FIELD_BITS-1:0] up_id_o,
  output logic [IDX_BITS-1:0]           up_idx_o,
  output logic [TRACK_BITS-1:0]         dn_trk_o,
  output logic [lds_pkg::FIELD_BITS-1:0] dn_id_o,
  output logic [IDX_BITS-1:0]           dn_idx_o,
  output logic [TRACK_BITS-1:0]         lo_trk_o,
  output logic [lds_pkg::FIELD_BITS-1:0] lo_id_o,
  output logic [IDX_BITS-1:0]           lo_idx_o
);
  import lds_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

  logic                  valid_r;
  logic [TRACK_BITS-1:0] trk_r;
  logic [FIELD_BITS-1:0] id_r;

  ctl_t                  ctl_nxt, ctl_r;
  logic [TRACK_BITS-1:0] up_trk_nxt, dn_trk_nxt, lo_trk_nxt;
  logic [FIELD_BITS-1:0] up_id_nxt, dn_id_nxt, lo_id_nxt;
  logic [IDX_BITS-1:0]   up_idx_nxt, dn_idx_nxt, lo_idx_nxt;
  logic [TRACK_BITS-1:0] up_trk_r, dn_trk_r, lo_trk_r;
  logic [FIELD_BITS-1:0] up_id_r, dn_id_r, lo_id_r;
  logic [IDX_BITS-1:0]   up_idx_r, dn_idx_r, lo_idx_r;
  logic                  take_add;

  assign take_add = ctl_i.live && ctl_i.add_req && !valid_r;

  always_comb begin
    ctl_nxt    = ctl_i;
    up_trk_nxt = up_trk_i;
    up_id_nxt  = up_id_i;
    up_idx_nxt = up_idx_i;
    dn_trk_nxt = dn_trk_i;
    dn_id_nxt  = dn_id_i;
    dn_idx_nxt = dn_idx_i;
    lo_trk_nxt = lo_trk_i;
    lo_id_nxt  = lo_id_i;
    lo_idx_nxt = lo_idx_i;
    if (ctl_i.add_req && !valid_r) begin
      ctl_nxt.add_req = 1'b0;
      ctl_nxt.placed  = 1'b1;
    end
    if (valid_r && trk_r > head_trk_i) begin
      ctl_nxt.any_above = 1'b1;
    end
    // Strictly better only: an earlier slot keeps a full tie
    if (valid_r && trk_r >= head_trk_i &&
        (!ctl_i.up_found || trk_r < up_trk_i ||
         (trk_r == up_trk_i && id_r < up_id_i))) begin
      ctl_nxt.up_found = 1'b1;
      up_trk_nxt = trk_r;
      up_id_nxt  = id_r;
      up_idx_nxt = MY_IDX;
    end
    if (valid_r && trk_r <= head_trk_i &&
        (!ctl_i.dn_found || trk_r > dn_trk_i ||
         (trk_r == dn_trk_i && id_r < dn_id_i))) begin
      ctl_nxt.dn_found = 1'b1;
      dn_trk_nxt = trk_r;
      dn_id_nxt  = id_r;
      dn_idx_nxt = MY_IDX;
    end
    if (valid_r && (!ctl_i.lo_found || id_r < lo_id_i)) begin
      ctl_nxt.lo_found = 1'b1;
      lo_trk_nxt = trk_r;
      lo_id_nxt  = id_r;
      lo_idx_nxt = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ctl_r   <= '0;
    end else begin
      if (take_add) begin
        valid_r <= 1'b1;
      end else if (clr_en_i && clr_idx_i == MY_IDX) begin
        valid_r <= 1'b0;
      end
      ctl_r <= ctl_i.live ? ctl_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_add) begin
      trk_r <= add_trk_i;
      id_r  <= add_id_i;
    end
    up_trk_r <= up_trk_nxt;
    up_id_r  <= up_id_nxt;
    up_idx_r <= up_idx_nxt;
    dn_trk_r <= dn_trk_nxt;
    dn_id_r  <= dn_id_nxt;
    dn_idx_r <= dn_idx_nxt;
    lo_trk_r <= lo_trk_nxt;
    lo_id_r  <= lo_id_nxt;
    lo_idx_r <= lo_idx_nxt;
  end

  assign ctl_o    = ctl_r;
  assign up_trk_o = up_trk_r;
  assign up_id_o  = up_id_r;
  assign up_idx_o = up_idx_r;
  assign dn_trk_o = dn_trk_r;
  assign dn_id_o  = dn_id_r;
  assign dn_idx_o = dn_idx_r;
  assign lo_trk_o = lo_trk_r;
  assign lo_id_o  = lo_id_r;
  assign lo_idx_o = lo_idx_r;

endmodule

`default_nettype wire

// ===== src/look_elevator_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// look_elevator_disk_scheduler - LOOK (elevator) disk request scheduler
// Stores pending requests in a chain of slot cells and grants them one at a
// time, sweeping the head up and down across the pending tracks.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   --------  -------------------------  -------------------------------------
//   input     start & !busy              in_action, in_request_track, in_request_id
//   result    out_strobe (one cycle)     out_grant_valid, out_grant_track,
//                                        out_grant_id, out_add_accepted,
//                                        out_store_empty
//
// Every transaction runs one pass down the chain of PENDING_DEPTH cells, one
// cell per cycle. Its result strobe is registered from the far end of the
// chain and the result is accepted at the edge that ends it; busy drops in
// that strobe cycle, so a new transaction can be taken at that same edge.
// No transaction is taken mid-pass; the chain length sets how long a pass lasts.
// Reset (rst_n low, synchronous) empties the store and forgets the head.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
`default_nettype none

module look_elevator_disk_scheduler #(
  parameter int PENDING_DEPTH = 16,
  parameter int TRACK_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [lds_pkg::FIELD_BITS-1:0] in_request_track,
  input  logic [lds_pkg::FIELD_BITS-1:0] in_request_id,
  output logic                          out_strobe,
  output logic                          out_grant_valid,
  output logic [lds_pkg::FIELD_BITS-1:0] out_grant_track,
  output logic [lds_pkg::FIELD_BITS-1:0] out_grant_id,
  output logic                          out_add_accepted,
  output logic                          out_store_empty
);
  import lds_pkg::*;

  localparam int IDX_BITS = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(PENDING_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(PENDING_DEPTH);

  // Chain wiring: index 0 is the launch point, PENDING_DEPTH the far end
  ctl_t                  ctl_c    [0:PENDING_DEPTH];
  logic [TRACK_BITS-1:0] up_trk_c [0:PENDING_DEPTH];
  logic [FIELD_BITS-1:0] up_id_c  [0:PENDING_DEPTH];
  logic [IDX_BITS-1:0]   up_idx_c [0:PENDING_DEPTH];
  logic [TRACK_BITS-1:0] dn_trk_c [0:PENDING_DEPTH];
  logic [FIELD_BITS-1:0] dn_id_c  [0:PENDING_DEPTH];
  logic [IDX_BITS-1:0]   dn_idx_c [0:PENDING_DEPTH];
  logic [TRACK_BITS-1:0] lo_trk_c [0:PENDING_DEPTH];
  logic [FIELD_BITS-1:0] lo_id_c  [0:PENDING_DEPTH];
  logic [IDX_BITS-1:0]   lo_idx_c [0:PENDING_DEPTH];

  ctl_t                  launch_ctl;
  logic                  busy_r;
  logic                  accept;
  logic [TRACK_BITS+FIELD_BITS-1:0] in_trk_wide;
  logic [TRACK_BITS-1:0] in_trk;
  logic [TRACK_BITS-1:0] add_trk_r, add_trk;
  logic [FIELD_BITS-1:0] add_id_r, add_id;

  logic [TRACK_BITS-1:0] head_r, head_nxt;
  dir_t                  dir_r, dir_nxt;
  logic                  known_r, known_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;

  // Decision at the end of the chain
  ctl_t                  end_ctl;
  logic                  grant;
  dir_t                  dir_eff;
  logic [TRACK_BITS-1:0] sel_trk;
  logic [FIELD_BITS-1:0] sel_id;
  logic [IDX_BITS-1:0]   sel_idx;
  logic [TRACK_BITS+FIELD_BITS-1:0] sel_trk_wide;

  logic                  out_strobe_r;
  logic                  out_grant_valid_r;
  logic [FIELD_BITS-1:0] out_grant_track_r;
  logic [FIELD_BITS-1:0] out_grant_id_r;
  logic                  out_add_accepted_r;
  logic                  out_store_empty_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Hold tracks in TRACK_BITS bits: zero-extend or truncate the port field
  assign in_trk_wide = {{TRACK_BITS{1'b0}}, in_request_track};
  assign in_trk      = in_trk_wide[TRACK_BITS-1:0];

  // Cell 0 sees the transaction on its accept edge, later cells see the held copy
  assign add_trk = busy_r ? add_trk_r : in_trk;
  assign add_id  = busy_r ? add_id_r  : in_request_id;

  // Launch bundle: empty candidates, flags from the transaction
  always_comb begin
    launch_ctl         = '0;
    launch_ctl.live    = accept;
    launch_ctl.pick    = in_action;
    launch_ctl.add_req = !in_action;
  end

  assign ctl_c[0]    = launch_ctl;
  assign up_trk_c[0] = '0;
  assign up_id_c[0]  = '0;
  assign up_idx_c[0] = '0;
  assign dn_trk_c[0] = '0;
  assign dn_id_c[0]  = '0;
  assign dn_idx_c[0] = '0;
  assign lo_trk_c[0] = '0;
  assign lo_id_c[0]  = '0;
  assign lo_idx_c[0] = '0;

  for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
    lds_cell #(
      .TRACK_BITS (TRACK_BITS),
      .IDX_BITS   (IDX_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl_c[g]),
      .head_trk_i (head_r),
      .add_trk_i  (add_trk),
      .add_id_i   (add_id),
      .clr_en_i   (grant),
      .clr_idx_i  (sel_idx),
      .up_trk_i   (up_trk_c[g]),
      .up_id_i    (up_id_c[g]),
      .up_idx_i   (up_idx_c[g]),
      .dn_trk_i   (dn_trk_c[g]),
      .dn_id_i    (dn_id_c[g]),
      .dn_idx_i   (dn_idx_c[g]),
      .lo_trk_i   (lo_trk_c[g]),
      .lo_id_i    (lo_id_c[g]),
      .lo_idx_i   (lo_idx_c[g]),
      .ctl_o      (ctl_c[g+1]),
      .up_trk_o   (up_trk_c[g+1]),
      .up_id_o    (up_id_c[g+1]),
      .up_idx_o   (up_idx_c[g+1]),
      .dn_trk_o   (dn_trk_c[g+1]),
      .dn_id_o    (dn_id_c[g+1]),
      .dn_idx_o   (dn_idx_c[g+1]),
      .lo_trk_o   (lo_trk_c[g+1]),
      .lo_id_o    (lo_id_c[g+1]),
      .lo_idx_o   (lo_idx_c[g+1])
    );
  end

  assign end_ctl = ctl_c[PENDING_DEPTH];

  // Choose the grant once the pass reaches the far end of the chain.
  // The lowest-id candidate exists exactly when the store is not empty.
  always_comb begin
    grant     = 1'b0;
    dir_eff   = dir_r;
    dir_nxt   = dir_r;
    head_nxt  = head_r;
    known_nxt = known_r;
    count_nxt = count_r;
    sel_trk   = lo_trk_c[PENDING_DEPTH];
    sel_id    = lo_id_c[PENDING_DEPTH];
    sel_idx   = lo_idx_c[PENDING_DEPTH];
    if (end_ctl.live) begin
      if (end_ctl.pick && end_ctl.lo_found) begin
        grant = 1'b1;
        if (known_r) begin
          // Fix the sweep on the first pick after the opening grant
          if (dir_r == DIR_NONE) begin
            dir_eff = end_ctl.any_above ? DIR_UP : DIR_DOWN;
          end
          dir_nxt = dir_eff;
          if (dir_eff == DIR_UP) begin
            if (end_ctl.up_found) begin
              sel_trk = up_trk_c[PENDING_DEPTH];
              sel_id  = up_id_c[PENDING_DEPTH];
              sel_idx = up_idx_c[PENDING_DEPTH];
            end else begin
              // Nothing above: reverse and take from below
              dir_nxt = DIR_DOWN;
              sel_trk = dn_trk_c[PENDING_DEPTH];
              sel_id  = dn_id_c[PENDING_DEPTH];
              sel_idx = dn_idx_c[PENDING_DEPTH];
            end
          end else begin
            if (end_ctl.dn_found) begin
              sel_trk = dn_trk_c[PENDING_DEPTH];
              sel_id  = dn_id_c[PENDING_DEPTH];
              sel_idx = dn_idx_c[PENDING_DEPTH];
            end else begin
              dir_nxt = DIR_UP;
              sel_trk = up_trk_c[PENDING_DEPTH];
              sel_id  = up_id_c[PENDING_DEPTH];
              sel_idx = up_idx_c[PENDING_DEPTH];
            end
          end
        end
        head_nxt  = sel_trk;
        known_nxt = 1'b1;
        count_nxt = count_r - CNT_BITS'(1);
      end else if (end_ctl.placed) begin
        count_nxt = count_r + CNT_BITS'(1);
      end
    end
  end

  assign sel_trk_wide = {{FIELD_BITS{1'b0}}, sel_trk};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      head_r       <= '0;
      dir_r        <= DIR_NONE;
      known_r      <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (end_ctl.live) begin
        busy_r <= 1'b0;
      end
      head_r       <= head_nxt;
      dir_r        <= dir_nxt;
      known_r      <= known_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= end_ctl.live;
    end
  end

  // Hold the add payload for the rest of the pass; load result fields at the end
  always_ff @(posedge clk) begin
    if (accept) begin
      add_trk_r <= in_trk;
      add_id_r  <= in_request_id;
    end
    if (end_ctl.live) begin
      out_grant_valid_r  <= grant;
      out_grant_track_r  <= grant ? sel_trk_wide[FIELD_BITS-1:0] : '0;
      out_grant_id_r     <= grant ? sel_id : '0;
      out_add_accepted_r <= !end_ctl.pick && end_ctl.placed;
      out_store_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_grant_valid  = out_grant_valid_r;
  assign out_grant_track  = out_grant_track_r;
  assign out_grant_id     = out_grant_id_r;
  assign out_add_accepted = out_add_accepted_r;
  assign out_store_empty  = out_store_empty_r;

  // Occupancy never passes the number of slots
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("pending count beyond store depth");

  // A result always follows a finished pass and frees the input side
  a_strobe_after_pass : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy_r && $past(end_ctl.live))
    else $error("result strobe without a finished pass");

  // A transaction is either a grant or an add, never both
  a_grant_xor_add : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !(out_grant_valid_r && out_add_accepted_r))
    else $error("grant and add reported together");

  // A grant only comes from a store that held something
  a_grant_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    grant |-> count_r != '0)
    else $error("grant from an empty store");

endmodule

`default_nettype wire

// ===== bench/tb_look_elevator_disk_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_elevator_disk_scheduler - self-checking bench for the LOOK scheduler
// Walks a short directed table of add and pick transactions, then a long
// random mix that fills, overflows and drains the request store. Every
// result is compared field by field with an in-bench prediction of the
// elevator sweep, or for pinned rows with the outcome typed into the row.
// ----------------------------------------------------------------------------

module tb_look_elevator_disk_scheduler;

  import lds_pkg::*;

  localparam int PENDING_DEPTH = 16;
  localparam int TRACK_BITS    = 16;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 3;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1625;
  // settle time after the last owed result, in whole passes
  localparam int SETTLE_CYCLES = 4 * (PENDING_DEPTH + 1);
  // slowest run: ~1650 transactions plus gaps between bursts and the odd
  // full drain, well inside this limit
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;
  localparam int DRAIN_EVERY   = 400;

  // transaction kinds on in_action
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_PICK = 1'b1;

  typedef struct packed {
    logic                  grant_valid;
    logic [FIELD_BITS-1:0] grant_track;
    logic [FIELD_BITS-1:0] grant_id;
    logic                  add_accepted;
    logic                  store_empty;
  } sched_outcome_t;

  typedef struct packed {
    logic                  action;
    logic [FIELD_BITS-1:0] track;
    logic [FIELD_BITS-1:0] req_id;
    logic                  pinned;  // use the outcome typed into the row
    sched_outcome_t        want;
  } stim_row_t;

  localparam sched_outcome_t NO_OUTCOME = '0;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  start            = 1'b0;
  logic                  busy;
  logic                  in_action        = ACT_ADD;
  logic [FIELD_BITS-1:0] in_request_track = '0;
  logic [FIELD_BITS-1:0] in_request_id    = '0;
  logic                  out_strobe;
  logic                  out_grant_valid;
  logic [FIELD_BITS-1:0] out_grant_track;
  logic [FIELD_BITS-1:0] out_grant_id;
  logic                  out_add_accepted;
  logic                  out_store_empty;

  look_elevator_disk_scheduler #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .TRACK_BITS    (TRACK_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_request_track (in_request_track),
    .in_request_id    (in_request_id),
    .out_strobe       (out_strobe),
    .out_grant_valid  (out_grant_valid),
    .out_grant_track  (out_grant_track),
    .out_grant_id     (out_grant_id),
    .out_add_accepted (out_add_accepted),
    .out_store_empty  (out_store_empty)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Scheduler prediction: a private copy of the request store, the head and
  // the sweep, advanced once per accepted transaction
  // --------------------------------------------------------------------------
  logic [FIELD_BITS-1:0] slot_track [PENDING_DEPTH];
  logic [FIELD_BITS-1:0] slot_id    [PENDING_DEPTH];
  logic                  slot_used  [PENDING_DEPTH];
  logic [FIELD_BITS-1:0] head_pos;
  dir_t                  sweep;
  logic                  head_valid;

  sched_outcome_t        owed_outcomes [$];
  int                    fault_count;
  int                    issued;
  int                    cycle_count;

  function automatic int occupancy();
    int n;
    int i;
    n = 0;
    for (i = 0; i < PENDING_DEPTH; i++)
      if (slot_used[i]) n++;
    return n;
  endfunction

  // Nearest pending slot at or beyond the head on side d, -1 if that side
  // is bare. A track equal to the head lies on both sides; equal tracks
  // fall to the lower id, equal ids to the lower slot.
  function automatic int nearest_on_side(dir_t d);
    int   best;
    int   i;
    logic beyond;
    logic nearer;
    best = -1;
    for (i = 0; i < PENDING_DEPTH; i++) begin
      if (slot_used[i]) begin
        beyond = (d == DIR_UP) ? (slot_track[i] >= head_pos) : (slot_track[i] <= head_pos);
        if (beyond) begin
          if (best < 0) begin
            best = i;
          end else begin
            nearer = (d == DIR_UP) ? (slot_track[i] < slot_track[best])
                                   : (slot_track[i] > slot_track[best]);
            if (nearer || (slot_track[i] == slot_track[best] && slot_id[i] < slot_id[best]))
              best = i;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic sched_outcome_t look_schedule_step(logic act,
                                                        logic [FIELD_BITS-1:0] trk,
                                                        logic [FIELD_BITS-1:0] rid);
    sched_outcome_t res;
    int             pick;
    int             i;
    res  = '0;
    pick = -1;
    if (act == ACT_ADD) begin
      // lowest free slot takes it; a full store drops the request
      for (i = 0; i < PENDING_DEPTH; i++) begin
        if (!slot_used[i] && !res.add_accepted) begin
          slot_used[i]     = 1'b1;
          slot_track[i]    = trk;
          slot_id[i]       = rid;
          res.add_accepted = 1'b1;
        end
      end
    end else if (occupancy() != 0) begin
      if (!head_valid) begin
        // first grant since reset: lowest request id
        for (i = 0; i < PENDING_DEPTH; i++)
          if (slot_used[i] && (pick < 0 || slot_id[i] < slot_id[pick])) pick = i;
      end else begin
        // settle the opening direction once: up if anything lies above
        if (sweep != DIR_UP && sweep != DIR_DOWN) begin
          sweep = DIR_DOWN;
          for (i = 0; i < PENDING_DEPTH; i++)
            if (slot_used[i] && slot_track[i] > head_pos) sweep = DIR_UP;
        end
        pick = nearest_on_side(sweep);
        if (pick < 0) begin
          // bare side: turn round, the other side must hold something
          sweep = (sweep == DIR_UP) ? DIR_DOWN : DIR_UP;
          pick  = nearest_on_side(sweep);
        end
      end
      if (pick >= 0) begin
        slot_used[pick] = 1'b0;
        head_pos        = slot_track[pick];
        head_valid      = 1'b1;
        res.grant_valid = 1'b1;
        res.grant_track = slot_track[pick];
        res.grant_id    = slot_id[pick];
      end
    end
    res.store_empty = (occupancy() == 0);
    return res;
  endfunction

  function automatic sched_outcome_t typed_outcome(logic gv, logic [FIELD_BITS-1:0] gt,
                                                   logic [FIELD_BITS-1:0] gi,
                                                   logic acc, logic empty);
    sched_outcome_t res;
    res.grant_valid  = gv;
    res.grant_track  = gt;
    res.grant_id     = gi;
    res.add_accepted = acc;
    res.store_empty  = empty;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Present one transaction and hold it until the block takes it (start high
  // and busy low at an edge). Must be called just after a rising edge. Start
  // is left high, so a back-to-back caller never lowers and raises it in the
  // same step.
  task automatic issue(input logic act, input logic [FIELD_BITS-1:0] trk,
                       input logic [FIELD_BITS-1:0] rid, input logic pinned,
                       input sched_outcome_t want);
    sched_outcome_t predicted;
    start            <= 1'b1;
    in_action        <= act;
    in_request_track <= trk;
    in_request_id    <= rid;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge: advance the prediction and queue what is owed
    predicted = look_schedule_step(act, trk, rid);
    owed_outcomes.push_back(pinned ? want : predicted);
    issued++;
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain_owed();
    start <= 1'b0;
    while (owed_outcomes.size() != 0) @(posedge clk);
  endtask

  stim_row_t directed_rows [DIRECTED_ROWS];

  initial begin : stimulus
    int                    k;
    int                    burst;
    int                    gap;
    int                    next_drain;
    logic                  filling;
    logic                  act;
    logic [FIELD_BITS-1:0] trk;
    logic [FIELD_BITS-1:0] rid;
    logic [FIELD_BITS-1:0] next_id;

    for (k = 0; k < PENDING_DEPTH; k++) begin
      slot_used[k]  = 1'b0;
      slot_track[k] = '0;
      slot_id[k]    = '0;
    end
    head_pos    = '0;
    sweep       = DIR_NONE;
    head_valid  = 1'b0;
    fault_count = 0;
    issued      = 0;

    // Directed table. Pinned rows carry their outcome; the rest are checked
    // against the prediction.
    // pick before anything was added
    directed_rows[0]  = '{ACT_PICK, 16'h0000, 16'h0000, 1'b1,
                          typed_outcome(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1)};
    // fill all sixteen slots: extreme tracks, a shared id, shared tracks
    directed_rows[1]  = '{ACT_ADD, 16'hFFFF, 16'h0005, 1'b1,
                          typed_outcome(1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0)};
    directed_rows[2]  = '{ACT_ADD, 16'h0000, 16'hFFFF, 1'b0, NO_OUTCOME};
    directed_rows[3]  = '{ACT_ADD, 16'h8000, 16'h0003, 1'b0, NO_OUTCOME};
    directed_rows[4]  = '{ACT_ADD, 16'h4000, 16'h0003, 1'b0, NO_OUTCOME};
    directed_rows[5]  = '{ACT_ADD, 16'h8000, 16'h0007, 1'b0, NO_OUTCOME};
    directed_rows[6]  = '{ACT_ADD, 16'h8000, 16'h0006, 1'b0, NO_OUTCOME};
    directed_rows[7]  = '{ACT_ADD, 16'h7FFF, 16'h0008, 1'b0, NO_OUTCOME};
    directed_rows[8]  = '{ACT_ADD, 16'h8001, 16'h0009, 1'b0, NO_OUTCOME};
    directed_rows[9]  = '{ACT_ADD, 16'h1234, 16'h000A, 1'b0, NO_OUTCOME};
    directed_rows[10] = '{ACT_ADD, 16'h2345, 16'h000B, 1'b0, NO_OUTCOME};
    directed_rows[11] = '{ACT_ADD, 16'h0001, 16'h000C, 1'b0, NO_OUTCOME};
    directed_rows[12] = '{ACT_ADD, 16'h0002, 16'h000D, 1'b0, NO_OUTCOME};
    directed_rows[13] = '{ACT_ADD, 16'h5555, 16'h000E, 1'b0, NO_OUTCOME};
    directed_rows[14] = '{ACT_ADD, 16'hAAAA, 16'h000F, 1'b0, NO_OUTCOME};
    directed_rows[15] = '{ACT_ADD, 16'h0000, 16'h0010, 1'b0, NO_OUTCOME};
    directed_rows[16] = '{ACT_ADD, 16'h3C3C, 16'h0011, 1'b0, NO_OUTCOME};
    // store full: this one is dropped
    directed_rows[17] = '{ACT_ADD, 16'hAAAA, 16'h5555, 1'b1,
                          typed_outcome(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0)};
    // first grant: lowest id, shared id settled by the lower slot
    directed_rows[18] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b1,
                          typed_outcome(1'b1, 16'h8000, 16'h0003, 1'b0, 1'b0)};
    // sweep up from the head: tracks equal to the head first, lower id
    // first, then on to the top and round the turn
    directed_rows[19] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};
    directed_rows[20] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};
    directed_rows[21] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};
    directed_rows[22] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};
    directed_rows[23] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};
    directed_rows[24] = '{ACT_PICK, 16'h0000, 16'h0000, 1'b0, NO_OUTCOME};

    // hold reset at the start of the run, once only
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++)
      issue(directed_rows[k].action, directed_rows[k].track, directed_rows[k].req_id,
            directed_rows[k].pinned, directed_rows[k].want);

    // Random part. Alternate between filling and draining the store so the
    // sweep sees every fill level, overflow and the empty store; ids mostly
    // climb in arrival order, tracks cluster round the head now and then to
    // produce ties and tracks equal to the head.
    filling    = 1'b1;
    next_id    = 16'h0100;
    next_drain = DIRECTED_ROWS + DRAIN_EVERY / 2;
    while (issued < DIRECTED_ROWS + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        // turn the tide: mostly at full or empty, now and then mid-way
        if (filling && occupancy() == PENDING_DEPTH && $urandom_range(0, 9) < 6)
          filling = 1'b0;
        else if (!filling && occupancy() == 0 && $urandom_range(0, 9) < 6)
          filling = 1'b1;
        else if ($urandom_range(0, 99) < 3)
          filling = !filling;

        if ($urandom_range(0, 99) < 15)
          act = 1'($urandom_range(0, 1));
        else
          act = filling ? ACT_ADD : ACT_PICK;

        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: trk = FIELD_BITS'($urandom_range(0, 16'hFFFF));
          5, 6, 7:       trk = FIELD_BITS'(head_pos + $urandom_range(0, 8) - 4);
          8:             trk = head_pos;
          default:       trk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase

        next_id = FIELD_BITS'(next_id + $urandom_range(1, 3));
        if ($urandom_range(0, 6) == 0)
          rid = FIELD_BITS'($urandom_range(0, 16'hFFFF));
        else
          rid = next_id;

        issue(act, trk, rid, 1'b0, NO_OUTCOME);
      end

      // now and then let everything come home before going on
      if (issued >= next_drain) begin
        drain_owed();
        next_drain += DRAIN_EVERY;
      end

      // gap after the burst; a quarter of bursts run straight on
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // wind down: wait for every owed result, then watch for strays
    drain_owed();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("tb_look_elevator_disk_scheduler: clean");
    else
      $display("tb_look_elevator_disk_scheduler: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: the receiver cannot stall, so take every strobe and match it
  // against the oldest owed outcome
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    sched_outcome_t want;
    logic           bad;
    if (rst_n && out_strobe) begin
      if (owed_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("[%0t] result with nothing owed: gv=%0b track=%h id=%h acc=%0b empty=%0b",
                   $time, out_grant_valid, out_grant_track, out_grant_id,
                   out_add_accepted, out_store_empty);
      end else begin
        want = owed_outcomes.pop_front();
        bad  = (out_grant_valid  !== want.grant_valid)  ||
               (out_grant_track  !== want.grant_track)  ||
               (out_grant_id     !== want.grant_id)     ||
               (out_add_accepted !== want.add_accepted) ||
               (out_store_empty  !== want.store_empty);
        if (bad) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch, expected gv=%0b track=%h id=%h acc=%0b empty=%0b",
                     $time, want.grant_valid, want.grant_track, want.grant_id,
                     want.add_accepted, want.store_empty);
            $display("[%0t]           actual   gv=%0b track=%h id=%h acc=%0b empty=%0b",
                     $time, out_grant_valid, out_grant_track, out_grant_id,
                     out_add_accepted, out_store_empty);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end a hung run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_look_elevator_disk_scheduler: errors");
    $finish;
  end

endmodule
